// ===== rtl/itlv_pkg.sv =====
`timescale 1ns / 1ps

package itlv_pkg;

	// Frame limit and derived widths
	localparam int unsigned MAX_FRAME_BYTES = 2048;
	localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 2);
	localparam int unsigned CMP_W = ((POS_W > 8) ? POS_W : 8) + 1;

	// Queue between front and back (depth is a power of two)
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Event and tag codes
	localparam logic [7:0] EVENT_INIT = 8'h22;
	localparam logic [7:0] TAG_CAPS = 8'h11;
	localparam logic [7:0] TAG_CHIP = 8'h12;
	localparam logic [7:0] TAG_EXT = 8'h16;
	localparam logic [7:0] TAG_FW = 8'h17;
	localparam logic [7:0] NO_CHIP = 8'hff;

	// Capability bit positions
	localparam int unsigned CAP_BLE_BIT = 3;
	localparam int unsigned CAP_BREDR_BIT = 4;
	localparam int unsigned CAP_SPI_BIT = 6;
	localparam int unsigned EXT_BTIF_BIT = 5;

	typedef enum logic [1:0] {
		KIND_TYPE = 2'd0,
		KIND_LEN = 2'd1,
		KIND_ITEM = 2'd2,
		KIND_SKIP = 2'd3
	} byte_kind_t;

	typedef enum logic [2:0] {
		STATUS_OK = 3'd0,
		STATUS_SHORT = 3'd1,
		STATUS_WRONG_TYPE = 3'd2,
		STATUS_BAD_LENGTH = 3'd3,
		STATUS_TRUNCATED = 3'd4,
		STATUS_NO_CHIP = 3'd5,
		STATUS_OVERSIZE = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		byte_kind_t kind;
		logic [POS_W-1:0] count;
	} entry_t;

	typedef struct packed {
		status_t status;
		logic [7:0] chip_id;
		logic [7:0] caps;
		logic [31:0] ext_caps;
		logic [31:0] fw_word;
		logic bt_supported;
		logic bt_dual_mode;
	} result_t;

endpackage

// ===== rtl/itlv_front.sv =====
`timescale 1ns / 1ps

module itlv_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic fifo_full,
	output logic full,
	output logic wr_en,
	output itlv_pkg::entry_t entry
);

	logic [itlv_pkg::POS_W-1:0] pos_q;
	logic [itlv_pkg::POS_W-1:0] pos_inc;
	logic in_range;

	// Accept a beat whenever the queue has room
	assign full = fifo_full;
	assign wr_en = push & ~fifo_full;

	// Classify the byte by its place in the frame
	assign in_range = (pos_q <= itlv_pkg::POS_W'(itlv_pkg::MAX_FRAME_BYTES));
	assign pos_inc = in_range ? (pos_q + 1'b1) : pos_q;

	always_comb begin
		entry.data = data_byte;
		entry.last = last_byte;
		entry.count = pos_inc;
		if (pos_q == '0) begin
			entry.kind = itlv_pkg::KIND_TYPE;
		end else if (pos_q == itlv_pkg::POS_W'(1)) begin
			entry.kind = itlv_pkg::KIND_LEN;
		end else if (in_range) begin
			entry.kind = itlv_pkg::KIND_ITEM;
		end else begin
			entry.kind = itlv_pkg::KIND_SKIP;
		end
	end

	// Advance the byte counter, saturating; restart at the frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr_en) begin
			pos_q <= last_byte ? '0 : pos_inc;
		end
	end

endmodule

// ===== rtl/itlv_fifo.sv =====
`timescale 1ns / 1ps

module itlv_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input itlv_pkg::entry_t wr_data,
	input logic rd_en,
	output itlv_pkg::entry_t rd_data,
	output logic full,
	output logic empty
);

	itlv_pkg::entry_t mem_q [itlv_pkg::QUEUE_DEPTH];
	logic [itlv_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [itlv_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [itlv_pkg::QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == itlv_pkg::QCNT_W'(itlv_pkg::QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= itlv_pkg::QCNT_W'(itlv_pkg::QUEUE_DEPTH))
		else $error("queue occupancy above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!full || rd_en))
		else $error("write into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("read from empty queue");
`endif

endmodule

// ===== rtl/itlv_back.sv =====
`timescale 1ns / 1ps

module itlv_back (
	input logic clk,
	input logic arst_n,
	input itlv_pkg::entry_t entry,
	input logic fifo_empty,
	output logic rd_en,
	input logic pop,
	output logic out_valid,
	output itlv_pkg::result_t result
);

	typedef enum logic [2:0] {
		PH_TAG = 3'b001,
		PH_LEN = 3'b010,
		PH_VAL = 3'b100
	} phase_t;

	phase_t phase_q, phase_n;
	logic hdr_bad_q, hdr_bad_n;
	logic [7:0] decl_q, decl_n;
	logic [7:0] tag_q, tag_n;
	logic [7:0] left_q, left_n;
	logic [7:0] size_q, size_n;
	logic [31:0] val_q, val_n;
	logic [7:0] chip_q, chip_n;
	logic [7:0] caps_q, caps_n;
	logic [31:0] ext_q, ext_n;
	logic [31:0] fw_q, fw_n;
	logic [7:0] idx;
	logic [itlv_pkg::CMP_W-1:0] cnt_ext;
	logic [itlv_pkg::CMP_W-1:0] decl_ext;
	itlv_pkg::status_t status_n;
	itlv_pkg::result_t res_n;
	itlv_pkg::result_t res_q;
	logic out_valid_q;
	logic out_pop;

	// Take the next entry unless it ends a frame and the result slot is busy
	assign out_pop = pop & out_valid_q;
	assign rd_en = ~fifo_empty & (~entry.last | ~out_valid_q | out_pop);
	assign out_valid = out_valid_q;
	assign result = res_q;
	assign idx = size_q - left_q;

	// Walk header and tag-length-value items
	always_comb begin
		phase_n = phase_q;
		hdr_bad_n = hdr_bad_q;
		decl_n = decl_q;
		tag_n = tag_q;
		left_n = left_q;
		size_n = size_q;
		val_n = val_q;
		chip_n = chip_q;
		caps_n = caps_q;
		ext_n = ext_q;
		fw_n = fw_q;
		case (entry.kind)
			itlv_pkg::KIND_TYPE: hdr_bad_n = (entry.data != itlv_pkg::EVENT_INIT);
			itlv_pkg::KIND_LEN: decl_n = entry.data;
			itlv_pkg::KIND_ITEM: begin
				case (phase_q)
					PH_TAG: begin
						tag_n = entry.data;
						phase_n = PH_LEN;
					end
					PH_LEN: begin
						size_n = entry.data;
						left_n = entry.data;
						val_n = '0;
						phase_n = (entry.data != 8'd0) ? PH_VAL : PH_TAG;
					end
					PH_VAL: begin
						if (idx[7:2] == 6'd0) begin
							val_n = val_q | ({24'd0, entry.data} << {idx[1:0], 3'b000});
						end
						left_n = left_q - 1'b1;
						if (left_n == 8'd0) begin
							phase_n = PH_TAG;
							// Commit known tags of the right size
							if (tag_q == itlv_pkg::TAG_CHIP && size_q == 8'd1) begin
								chip_n = val_n[7:0];
							end else if (tag_q == itlv_pkg::TAG_CAPS && size_q == 8'd1) begin
								caps_n = val_n[7:0];
							end else if (tag_q == itlv_pkg::TAG_FW && size_q == 8'd4) begin
								fw_n = val_n;
							end else if (tag_q == itlv_pkg::TAG_EXT && size_q == 8'd4) begin
								ext_n = val_n;
							end
						end
					end
					default: phase_n = PH_TAG;
				endcase
			end
			default: ;
		endcase
	end

	// Rank the frame errors
	assign cnt_ext = itlv_pkg::CMP_W'(entry.count);
	assign decl_ext = itlv_pkg::CMP_W'(decl_n) + itlv_pkg::CMP_W'(2);

	always_comb begin
		if (cnt_ext > itlv_pkg::CMP_W'(itlv_pkg::MAX_FRAME_BYTES)) begin
			status_n = itlv_pkg::STATUS_OVERSIZE;
		end else if (cnt_ext < itlv_pkg::CMP_W'(2)) begin
			status_n = itlv_pkg::STATUS_SHORT;
		end else if (hdr_bad_n) begin
			status_n = itlv_pkg::STATUS_WRONG_TYPE;
		end else if (decl_ext > cnt_ext) begin
			status_n = itlv_pkg::STATUS_BAD_LENGTH;
		end else if (phase_n == PH_VAL && left_n != 8'd0) begin
			status_n = itlv_pkg::STATUS_TRUNCATED;
		end else if (chip_n == itlv_pkg::NO_CHIP) begin
			status_n = itlv_pkg::STATUS_NO_CHIP;
		end else begin
			status_n = itlv_pkg::STATUS_OK;
		end
	end

	// Build the result; on any error zero the fields and set chip_id to NO_CHIP
	always_comb begin
		res_n.status = status_n;
		if (status_n == itlv_pkg::STATUS_OK) begin
			res_n.chip_id = chip_n;
			res_n.caps = caps_n;
			res_n.ext_caps = ext_n;
			res_n.fw_word = fw_n;
			res_n.bt_supported = caps_n[itlv_pkg::CAP_BLE_BIT] &
				(caps_n[itlv_pkg::CAP_SPI_BIT] | ext_n[itlv_pkg::EXT_BTIF_BIT]);
			res_n.bt_dual_mode = caps_n[itlv_pkg::CAP_BREDR_BIT];
		end else begin
			res_n.chip_id = itlv_pkg::NO_CHIP;
			res_n.caps = '0;
			res_n.ext_caps = '0;
			res_n.fw_word = '0;
			res_n.bt_supported = 1'b0;
			res_n.bt_dual_mode = 1'b0;
		end
	end

	// Advance parser state; restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			hdr_bad_q <= 1'b0;
			decl_q <= '0;
			tag_q <= '0;
			left_q <= '0;
			size_q <= '0;
			val_q <= '0;
			chip_q <= itlv_pkg::NO_CHIP;
			caps_q <= '0;
			ext_q <= '0;
			fw_q <= '0;
		end else if (rd_en) begin
			if (entry.last) begin
				phase_q <= PH_TAG;
				hdr_bad_q <= 1'b0;
				decl_q <= '0;
				tag_q <= '0;
				left_q <= '0;
				size_q <= '0;
				val_q <= '0;
				chip_q <= itlv_pkg::NO_CHIP;
				caps_q <= '0;
				ext_q <= '0;
				fw_q <= '0;
			end else begin
				phase_q <= phase_n;
				hdr_bad_q <= hdr_bad_n;
				decl_q <= decl_n;
				tag_q <= tag_n;
				left_q <= left_n;
				size_q <= size_n;
				val_q <= val_n;
				chip_q <= chip_n;
				caps_q <= caps_n;
				ext_q <= ext_n;
				fw_q <= fw_n;
			end
		end
	end

	// Hold the result until popped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_en && entry.last) begin
			out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en && entry.last) begin
			res_q <= res_n;
		end
	end

`ifndef ASSERT_OFF
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("item phase not one-hot");

	a_val_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VAL) |-> (left_q != 8'd0))
		else $error("value phase with no bytes left");

	a_ok_has_chip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == itlv_pkg::STATUS_OK) |->
			(res_q.chip_id != itlv_pkg::NO_CHIP))
		else $error("ok status without chip id");

	a_err_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status != itlv_pkg::STATUS_OK) |->
			(res_q.chip_id == itlv_pkg::NO_CHIP && res_q.caps == 8'd0 &&
			 res_q.ext_caps == 32'd0 && res_q.fw_word == 32'd0 &&
			 !res_q.bt_supported && !res_q.bt_dual_mode))
		else $error("error result carries fields");

	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && entry.last) |=> out_valid_q)
		else $error("frame end did not load a result");
`endif

endmodule

// ===== rtl/init_event_tlv_parser_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake             Beat fields
// input     push / full           data_byte, last_byte
// result    empty / pop           status, chip_id, capability_bits,
//                                 extended_capabilities, firmware_release,
//                                 bt_supported, bt_dual_mode
//
// One byte per cycle sustained while full is low; a frame's result is registered on the
// result ports when the parser reads its last byte (queue write, then parser read).
// The parser retires one queued byte per cycle; a last byte waits only while
// the single result register holds an unpopped result.
// Reset (arst_n low) clears the byte counter, the queue and all parser state.
// full rises once the four-entry queue fills; results hold until popped.

module init_event_tlv_parser_unit (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic empty,
	input logic pop,
	output logic [2:0] status,
	output logic [7:0] chip_id,
	output logic [7:0] capability_bits,
	output logic [31:0] extended_capabilities,
	output logic [31:0] firmware_release,
	output logic bt_supported,
	output logic bt_dual_mode
);

	logic fifo_full;
	logic fifo_empty;
	logic wr_en;
	logic rd_en;
	logic out_valid;
	itlv_pkg::entry_t wr_entry;
	itlv_pkg::entry_t rd_entry;
	itlv_pkg::result_t result;

	// Count and classify incoming bytes
	itlv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.fifo_full(fifo_full),
		.full(full),
		.wr_en(wr_en),
		.entry(wr_entry)
	);

	// Decouple front from parser
	itlv_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_data(wr_entry),
		.rd_en(rd_en),
		.rd_data(rd_entry),
		.full(fifo_full),
		.empty(fifo_empty)
	);

	// Parse items and hold the frame result
	itlv_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.entry(rd_entry),
		.fifo_empty(fifo_empty),
		.rd_en(rd_en),
		.pop(pop),
		.out_valid(out_valid),
		.result(result)
	);

	// Drive result ports
	assign empty = ~out_valid;
	assign status = result.status;
	assign chip_id = result.chip_id;
	assign capability_bits = result.caps;
	assign extended_capabilities = result.ext_caps;
	assign firmware_release = result.fw_word;
	assign bt_supported = result.bt_supported;
	assign bt_dual_mode = result.bt_dual_mode;

endmodule

// ===== bench/tb_init_event_tlv_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_init_event_tlv_parser_unit;

	localparam int unsigned TOTAL_BYTES = 1250;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		WANT_TAG,
		WANT_LEN,
		WANT_VALUE
	} tlv_phase_t;

	// Frame predictor: follows the byte stream, queues one expected result per frame
	class init_event_checker;
		int unsigned pos;
		logic hdr_bad;
		logic [7:0] decl_len;
		tlv_phase_t phase;
		logic [7:0] tag;
		logic [7:0] left;
		logic [7:0] size;
		logic [31:0] acc;
		logic [7:0] chip;
		logic [7:0] caps;
		logic [31:0] ext;
		logic [31:0] fw;
		itlv_pkg::result_t reports[$];
		int unsigned failures;

		function new();
			failures = 0;
			clear();
		endfunction

		function void clear();
			pos = 0;
			hdr_bad = 1'b0;
			decl_len = '0;
			phase = WANT_TAG;
			tag = '0;
			left = '0;
			size = '0;
			acc = '0;
			chip = itlv_pkg::NO_CHIP;
			caps = '0;
			ext = '0;
			fw = '0;
		endfunction

		// Keep a known tag only when its length matches
		function void store_item();
			if (tag == itlv_pkg::TAG_CHIP && size == 8'd1)
				chip = acc[7:0];
			else if (tag == itlv_pkg::TAG_CAPS && size == 8'd1)
				caps = acc[7:0];
			else if (tag == itlv_pkg::TAG_FW && size == 8'd4)
				fw = acc;
			else if (tag == itlv_pkg::TAG_EXT && size == 8'd4)
				ext = acc;
		endfunction

		function void take_byte(logic [7:0] b, logic last);
			logic [7:0] idx;
			itlv_pkg::result_t want;
			itlv_pkg::status_t st;
			if (pos == 0) begin
				hdr_bad = (b != itlv_pkg::EVENT_INIT);
			end else if (pos == 1) begin
				decl_len = b;
			end else if (pos <= itlv_pkg::MAX_FRAME_BYTES) begin
				case (phase)
					WANT_TAG: begin
						tag = b;
						phase = WANT_LEN;
					end
					WANT_LEN: begin
						size = b;
						left = b;
						acc = '0;
						phase = (b != 8'd0) ? WANT_VALUE : WANT_TAG;
					end
					default: begin
						idx = size - left;
						if (idx < 8'd4)
							acc = acc | (32'(b) << (8 * idx));
						left = left - 8'd1;
						if (left == 8'd0) begin
							store_item();
							phase = WANT_TAG;
						end
					end
				endcase
			end
			// Saturate the count just past the frame limit
			if (pos <= itlv_pkg::MAX_FRAME_BYTES)
				pos++;
			if (!last)
				return;

			if (pos > itlv_pkg::MAX_FRAME_BYTES)
				st = itlv_pkg::STATUS_OVERSIZE;
			else if (pos < 2)
				st = itlv_pkg::STATUS_SHORT;
			else if (hdr_bad)
				st = itlv_pkg::STATUS_WRONG_TYPE;
			else if (decl_len > pos - 2)
				st = itlv_pkg::STATUS_BAD_LENGTH;
			else if (phase == WANT_VALUE && left != 8'd0)
				st = itlv_pkg::STATUS_TRUNCATED;
			else if (chip == itlv_pkg::NO_CHIP)
				st = itlv_pkg::STATUS_NO_CHIP;
			else
				st = itlv_pkg::STATUS_OK;

			want = '0;
			want.status = st;
			want.chip_id = itlv_pkg::NO_CHIP;
			if (st == itlv_pkg::STATUS_OK) begin
				want.chip_id = chip;
				want.caps = caps;
				want.ext_caps = ext;
				want.fw_word = fw;
				want.bt_supported = caps[itlv_pkg::CAP_BLE_BIT] &&
					(caps[itlv_pkg::CAP_SPI_BIT] || ext[itlv_pkg::EXT_BTIF_BIT]);
				want.bt_dual_mode = caps[itlv_pkg::CAP_BREDR_BIT];
			end
			reports.push_back(want);
			clear();
		endfunction

		function void note_failure(string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("mismatch: %s", msg);
		endfunction

		function void compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
		endfunction

		function void check_report(itlv_pkg::result_t got);
			itlv_pkg::result_t want;
			if (reports.size() == 0) begin
				note_failure($sformatf("result beat with none pending, status %0d", got.status));
				return;
			end
			want = reports.pop_front();
			compare_field("status", 32'(got.status), 32'(want.status));
			compare_field("chip_id", 32'(got.chip_id), 32'(want.chip_id));
			compare_field("capability_bits", 32'(got.caps), 32'(want.caps));
			compare_field("extended_capabilities", got.ext_caps, want.ext_caps);
			compare_field("firmware_release", got.fw_word, want.fw_word);
			compare_field("bt_supported", 32'(got.bt_supported), 32'(want.bt_supported));
			compare_field("bt_dual_mode", 32'(got.bt_dual_mode), 32'(want.bt_dual_mode));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	logic [7:0] data_byte;
	logic last_byte;
	logic empty;
	logic pop;
	logic [2:0] status;
	logic [7:0] chip_id;
	logic [7:0] capability_bits;
	logic [31:0] extended_capabilities;
	logic [31:0] firmware_release;
	logic bt_supported;
	logic bt_dual_mode;

	init_event_checker sb = new();
	logic [7:0] frame_bytes[$];
	int unsigned sent_bytes = 0;
	int unsigned cycle_count = 0;
	bit steady = 1'b0;

	init_event_tlv_parser_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.status(status),
		.chip_id(chip_id),
		.capability_bits(capability_bits),
		.extended_capabilities(extended_capabilities),
		.firmware_release(firmware_release),
		.bt_supported(bt_supported),
		.bt_dual_mode(bt_dual_mode)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: check each popped beat, then stall at random
	initial begin
		itlv_pkg::result_t got;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				got.status = itlv_pkg::status_t'(status);
				got.chip_id = chip_id;
				got.caps = capability_bits;
				got.ext_caps = extended_capabilities;
				got.fw_word = firmware_release;
				got.bt_supported = bt_supported;
				got.bt_dual_mode = bt_dual_mode;
				sb.check_report(got);
			end
			pop <= steady || ($urandom_range(0, 99) >= 15);
		end
	end

	// Push one byte, idling first at random; hold it until accepted
	task automatic send_byte(logic [7:0] b, logic last);
		if (!steady && $urandom_range(0, 99) < 15) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (full);
		sb.take_byte(b, last);
		sent_bytes++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	function automatic void add_item(logic [7:0] tag, int unsigned len);
		frame_bytes.push_back(tag);
		frame_bytes.push_back(len[7:0]);
		repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Add one item: usually a known tag at its proper length, sometimes not
	function automatic void add_random_item(bit want_chip);
		logic [7:0] tag;
		int unsigned len;
		case (want_chip ? 0 : $urandom_range(0, 4))
			0: tag = itlv_pkg::TAG_CHIP;
			1: tag = itlv_pkg::TAG_CAPS;
			2: tag = itlv_pkg::TAG_EXT;
			3: tag = itlv_pkg::TAG_FW;
			default: tag = 8'($urandom_range(0, 255));
		endcase
		if (tag == itlv_pkg::TAG_CHIP || tag == itlv_pkg::TAG_CAPS)
			len = 1;
		else if (tag == itlv_pkg::TAG_EXT || tag == itlv_pkg::TAG_FW)
			len = 4;
		else
			len = $urandom_range(0, 6);
		if ($urandom_range(0, 7) == 0)
			len = $urandom_range(0, 6);
		if ($urandom_range(0, 49) == 0)
			len = $urandom_range(7, 255);
		if (tag == itlv_pkg::TAG_CHIP && len == 1 && $urandom_range(0, 19) == 0) begin
			frame_bytes.push_back(tag);
			frame_bytes.push_back(8'd1);
			frame_bytes.push_back(itlv_pkg::NO_CHIP);
		end else begin
			add_item(tag, len);
		end
	endfunction

	function automatic void build_tlv_frame();
		int unsigned n_items;
		int unsigned room;
		frame_bytes.delete();
		frame_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
			: itlv_pkg::EVENT_INIT);
		frame_bytes.push_back(8'd0);
		n_items = $urandom_range(0, 6);
		for (int i = 0; i < n_items; i++)
			add_random_item(i == 0 && $urandom_range(0, 99) < 85);
		// Lone trailing tag byte
		if ($urandom_range(0, 9) == 0)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		// Cut the frame short
		if ($urandom_range(0, 9) == 0 && frame_bytes.size() > 2)
			repeat ($urandom_range(1, 3)) begin
				if (frame_bytes.size() > 1)
					void'(frame_bytes.pop_back());
			end
		if (frame_bytes.size() >= 2) begin
			room = frame_bytes.size() - 2;
			if (room > 255)
				room = 255;
			frame_bytes[1] = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
				: $urandom_range(0, room));
		end
	endfunction

	function automatic void build_noise_frame();
		frame_bytes.delete();
		repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 9) < 3)
			frame_bytes[0] = itlv_pkg::EVENT_INIT;
	endfunction

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each status code but oversize, and the special cases
		frame_bytes = '{itlv_pkg::EVENT_INIT};
		send_frame();
		frame_bytes = '{8'hff, 8'h00};
		send_frame();
		frame_bytes = '{itlv_pkg::EVENT_INIT, 8'hff, itlv_pkg::TAG_CHIP};
		send_frame();
		frame_bytes = '{itlv_pkg::EVENT_INIT, 8'h00, itlv_pkg::TAG_EXT, 8'h04, 8'h01};
		send_frame();
		frame_bytes = '{itlv_pkg::EVENT_INIT, 8'h01, itlv_pkg::TAG_CHIP, 8'h01,
			itlv_pkg::NO_CHIP};
		send_frame();
		// Wrong-length firmware item, repeated chip id, lone trailing byte
		frame_bytes = '{itlv_pkg::EVENT_INIT, 8'h0c, itlv_pkg::TAG_CHIP, 8'h01, 8'h3c,
			itlv_pkg::TAG_CAPS, 8'h01, 8'h58, itlv_pkg::TAG_FW, 8'h02, 8'haa, 8'hbb,
			itlv_pkg::TAG_CHIP, 8'h01, 8'h07, 8'h5a};
		send_frame();

		// Random frames, mostly well formed
		while (sent_bytes < TOTAL_BYTES) begin
			steady = (sent_bytes >= 400 && sent_bytes < 700);
			if ($urandom_range(0, 99) < 70)
				build_tlv_frame();
			else
				build_noise_frame();
			send_frame();
		end
		steady = 1'b0;
		push <= 1'b0;

		// Drain pending reports, then give the block time to show stray beats
		while (sb.reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.reports.size() != 0)
			sb.note_failure($sformatf("%0d reports never arrived", sb.reports.size()));
		if (sb.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
